@@ rtl/core/prx_pkg.sv @@
// ----------------------------------------------------------------------------
// prx_pkg
// Shared types and constants for the pixel run region extractor.
// ----------------------------------------------------------------------------
package prx_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned PIXEL_BITS = 32;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned APB_ADDR_BITS = 4;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS:0]   coord_ext_t;
  typedef logic [PIXEL_BITS-1:0] pixel_t;

  localparam coord_t COORD_MAX = {COORD_BITS{1'b1}};

  localparam pixel_t KEY_COLOR_RST    = 32'h00FF_FFFF;
  localparam coord_t IMAGE_WIDTH_RST  = 12'd438;
  localparam coord_t IMAGE_HEIGHT_RST = 12'd592;
  localparam coord_t BATCH_LIMIT_RST  = 12'd200;

  typedef enum logic [1:0] {
    REG_KEY_COLOR    = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2,
    REG_BATCH_LIMIT  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    pixel_t key_color;
    coord_t image_width;
    coord_t image_height;
    coord_t batch_limit;
  } cfg_t;

  // Event handed from the front to the back: a closed run and/or frame end.
  typedef struct packed {
    logic   closed;
    logic   frame_last;
    coord_t left;
    coord_t right;
    coord_t row;
  } event_t;

  typedef struct packed {
    logic   run_valid;
    coord_t run_left;
    coord_t run_right;
    coord_t run_row;
    coord_t box_left;
    coord_t box_top;
    coord_t box_right;
    coord_t box_bottom;
    logic   batch_end;
    logic   frame_end;
  } result_t;

  // Status of a two-entry queue as seen by its producer and consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ rtl/core/prx_cfg.sv @@
// ----------------------------------------------------------------------------
// prx_cfg
// APB register file holding key color, image size and batch limit.
// ----------------------------------------------------------------------------
module prx_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [prx_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [prx_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [prx_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output prx_pkg::cfg_t                       cfg_o
);

  prx_pkg::cfg_t    cfg_q, cfg_d;
  prx_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = prx_pkg::reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        prx_pkg::REG_KEY_COLOR:    cfg_d.key_color    = pwdata;
        prx_pkg::REG_IMAGE_WIDTH:  cfg_d.image_width  = pwdata[prx_pkg::COORD_BITS-1:0];
        prx_pkg::REG_IMAGE_HEIGHT: cfg_d.image_height = pwdata[prx_pkg::COORD_BITS-1:0];
        prx_pkg::REG_BATCH_LIMIT:  cfg_d.batch_limit  = pwdata[prx_pkg::COORD_BITS-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      prx_pkg::REG_KEY_COLOR:    prdata = cfg_q.key_color;
      prx_pkg::REG_IMAGE_WIDTH:  prdata = {20'd0, cfg_q.image_width};
      prx_pkg::REG_IMAGE_HEIGHT: prdata = {20'd0, cfg_q.image_height};
      prx_pkg::REG_BATCH_LIMIT:  prdata = {20'd0, cfg_q.batch_limit};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_color    <= prx_pkg::KEY_COLOR_RST;
      cfg_q.image_width  <= prx_pkg::IMAGE_WIDTH_RST;
      cfg_q.image_height <= prx_pkg::IMAGE_HEIGHT_RST;
      cfg_q.batch_limit  <= prx_pkg::BATCH_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/prx_front.sv @@
// ----------------------------------------------------------------------------
// prx_front
// Pixel intake: key compare, raster position and run tracking.
// ----------------------------------------------------------------------------
module prx_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  prx_pkg::cfg_t        cfg_i,
  input  logic                 push_i,
  input  prx_pkg::pixel_t      pixel_i,
  input  prx_pkg::q_status_t   evq_status_i,
  output logic                 full_o,
  output logic                 ev_push_o,
  output prx_pkg::event_t      ev_o
);

  prx_pkg::coord_t     col_q, col_d;
  prx_pkg::coord_t     row_q, row_d;
  prx_pkg::coord_t     start_q, start_d;
  logic                in_run_q, in_run_d;

  prx_pkg::coord_ext_t col_p1, row_p1;
  logic                accept, is_key, last_col, last_row, closed, frame_last;

  assign full_o = evq_status_i.full;
  assign accept = push_i & ~evq_status_i.full;

  assign is_key     = (pixel_i == cfg_i.key_color);
  assign col_p1     = {1'b0, col_q} + 1'b1;
  assign row_p1     = {1'b0, row_q} + 1'b1;
  assign last_col   = col_p1 >= {1'b0, cfg_i.image_width};
  assign last_row   = row_p1 >= {1'b0, cfg_i.image_height};
  assign frame_last = last_col & last_row;
  assign closed     = is_key ? in_run_q : last_col;

  always_comb begin
    ev_o.closed     = closed;
    ev_o.frame_last = frame_last;
    ev_o.left       = in_run_q ? start_q : col_q;
    ev_o.right      = is_key ? col_q : col_p1[prx_pkg::COORD_BITS-1:0];
    ev_o.row        = row_q;
  end

  assign ev_push_o = accept & (closed | frame_last);

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    start_d  = start_q;
    in_run_d = in_run_q;
    if (accept) begin
      if (!is_key && !in_run_q) begin
        start_d = col_q;
      end
      if (closed) begin
        in_run_d = 1'b0;
      end else if (!is_key) begin
        in_run_d = 1'b1;
      end
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_p1[prx_pkg::COORD_BITS-1:0];
      end else begin
        col_d = col_p1[prx_pkg::COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      start_q  <= '0;
      in_run_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      start_q  <= start_d;
      in_run_q <= in_run_d;
    end
  end

endmodule

@@ rtl/core/prx_evq.sv @@
// ----------------------------------------------------------------------------
// prx_evq
// Two-entry event queue between the front and the back.
// ----------------------------------------------------------------------------
module prx_evq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  prx_pkg::event_t     data_i,
  input  logic                pop_i,
  output prx_pkg::event_t     data_o,
  output prx_pkg::q_status_t  status_o
);

  prx_pkg::event_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign status_o.full  = cnt_q == 2'd2;
  assign status_o.empty = cnt_q == 2'd0;
  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & ~status_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ rtl/core/prx_back.sv @@
// ----------------------------------------------------------------------------
// prx_back
// Batch bounding box, batch count and the two-entry result queue.
// ----------------------------------------------------------------------------
module prx_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prx_pkg::cfg_t       cfg_i,
  input  prx_pkg::event_t     ev_i,
  input  prx_pkg::q_status_t  evq_status_i,
  output logic                ev_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output prx_pkg::result_t    res_o
);

  prx_pkg::coord_t  bl_q, bl_d, bt_q, bt_d, br_q, br_d, bb_q, bb_d;
  prx_pkg::coord_t  cnt_q, cnt_d;
  prx_pkg::coord_t  bl_n, bt_n, br_n, bb_n, cnt_p1, bottom;
  logic             flush;
  prx_pkg::result_t res;

  prx_pkg::result_t oq_q [2];
  logic             oq_wr_q, oq_wr_d, oq_rd_q, oq_rd_d;
  logic [1:0]       oq_cnt_q, oq_cnt_d;
  logic             oq_full, oq_push, oq_pop;

  assign oq_full  = oq_cnt_q == 2'd2;
  assign empty_o  = oq_cnt_q == 2'd0;
  assign ev_pop_o = ~evq_status_i.empty & ~oq_full;
  assign oq_push  = ev_pop_o;
  assign oq_pop   = pop_i & ~empty_o;
  assign res_o    = oq_q[oq_rd_q];

  assign bottom = ev_i.row + 1'b1;
  assign cnt_p1 = cnt_q + 1'b1;

  // Fold the closed run into the box before a flush reports it.
  always_comb begin
    bl_n = bl_q;
    bt_n = bt_q;
    br_n = br_q;
    bb_n = bb_q;
    if (ev_i.closed) begin
      bl_n = (ev_i.left < bl_q) ? ev_i.left : bl_q;
      bt_n = (ev_i.row < bt_q) ? ev_i.row : bt_q;
      br_n = (ev_i.right > br_q) ? ev_i.right : br_q;
      bb_n = (bottom > bb_q) ? bottom : bb_q;
    end
    flush = (ev_i.closed && (cnt_p1 >= cfg_i.batch_limit)) || ev_i.frame_last;
  end

  always_comb begin
    res.run_valid  = ev_i.closed;
    res.run_left   = ev_i.closed ? ev_i.left : '0;
    res.run_right  = ev_i.closed ? ev_i.right : '0;
    res.run_row    = ev_i.closed ? ev_i.row : '0;
    res.box_left   = flush ? bl_n : '0;
    res.box_top    = flush ? bt_n : '0;
    res.box_right  = flush ? br_n : '0;
    res.box_bottom = flush ? bb_n : '0;
    res.batch_end  = flush;
    res.frame_end  = ev_i.frame_last;
  end

  always_comb begin
    bl_d  = bl_q;
    bt_d  = bt_q;
    br_d  = br_q;
    bb_d  = bb_q;
    cnt_d = cnt_q;
    if (ev_pop_o) begin
      if (flush) begin
        bl_d  = prx_pkg::COORD_MAX;
        bt_d  = prx_pkg::COORD_MAX;
        br_d  = '0;
        bb_d  = '0;
        cnt_d = '0;
      end else begin
        bl_d  = bl_n;
        bt_d  = bt_n;
        br_d  = br_n;
        bb_d  = bb_n;
        cnt_d = ev_i.closed ? cnt_p1 : cnt_q;
      end
    end
  end

  always_comb begin
    oq_wr_d  = oq_wr_q ^ oq_push;
    oq_rd_d  = oq_rd_q ^ oq_pop;
    oq_cnt_d = oq_cnt_q + {1'b0, oq_push} - {1'b0, oq_pop};
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[oq_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bl_q     <= prx_pkg::COORD_MAX;
      bt_q     <= prx_pkg::COORD_MAX;
      br_q     <= '0;
      bb_q     <= '0;
      cnt_q    <= '0;
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= '0;
    end else begin
      bl_q     <= bl_d;
      bt_q     <= bt_d;
      br_q     <= br_d;
      bb_q     <= bb_d;
      cnt_q    <= cnt_d;
      oq_wr_q  <= oq_wr_d;
      oq_rd_q  <= oq_rd_d;
      oq_cnt_q <= oq_cnt_d;
    end
  end

endmodule

@@ rtl/core/pixel_run_region_extractor.sv @@
// ----------------------------------------------------------------------------
// pixel_run_region_extractor
// Turns raster-order pixels into horizontal run rectangles and batch boxes.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while full is low, top row first. Every pixel
// equal to key_color is background; each horizontal run of other pixels
// comes out as one item (left, right exclusive, row), and batch_end items
// carry the bounding box of the runs since the previous batch_end; a batch
// ends once batch_limit runs are reached or at frame end. The last pixel of
// a frame always produces an item with frame_end set. Pixels that close no
// run and end no batch produce nothing. The front stage (key compare,
// column/row count, run start) writes events into a two-entry queue; the
// back stage (box and batch count) drains one event per clock, while the
// result queue has room, into a two-entry result queue. full rises only
// when both queues are backed up by a stalled consumer. Write the
// configuration registers only while no pixel is in flight.
// ----------------------------------------------------------------------------
module pixel_run_region_extractor (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [prx_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [prx_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [prx_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  input  logic                               push,
  output logic                               full,
  input  logic [prx_pkg::PIXEL_BITS-1:0]     pixel_value_i,
  output logic                               empty,
  input  logic                               pop,
  output logic                               run_valid_o,
  output logic [prx_pkg::COORD_BITS-1:0]     run_left_o,
  output logic [prx_pkg::COORD_BITS-1:0]     run_right_o,
  output logic [prx_pkg::COORD_BITS-1:0]     run_row_o,
  output logic [prx_pkg::COORD_BITS-1:0]     box_left_o,
  output logic [prx_pkg::COORD_BITS-1:0]     box_top_o,
  output logic [prx_pkg::COORD_BITS-1:0]     box_right_o,
  output logic [prx_pkg::COORD_BITS-1:0]     box_bottom_o,
  output logic                               batch_end_o,
  output logic                               frame_end_o
);

  prx_pkg::cfg_t      cfg;
  prx_pkg::q_status_t evq_status;
  prx_pkg::event_t    ev_in, ev_out;
  prx_pkg::result_t   res;
  logic               ev_push, ev_pop;

  prx_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  prx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .push_i       (push),
    .pixel_i      (pixel_value_i),
    .evq_status_i (evq_status),
    .full_o       (full),
    .ev_push_o    (ev_push),
    .ev_o         (ev_in)
  );

  prx_evq u_evq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (ev_push),
    .data_i   (ev_in),
    .pop_i    (ev_pop),
    .data_o   (ev_out),
    .status_o (evq_status)
  );

  prx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .ev_i         (ev_out),
    .evq_status_i (evq_status),
    .ev_pop_o     (ev_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .res_o        (res)
  );

  assign run_valid_o  = res.run_valid;
  assign run_left_o   = res.run_left;
  assign run_right_o  = res.run_right;
  assign run_row_o    = res.run_row;
  assign box_left_o   = res.box_left;
  assign box_top_o    = res.box_top;
  assign box_right_o  = res.box_right;
  assign box_bottom_o = res.box_bottom;
  assign batch_end_o  = res.batch_end;
  assign frame_end_o  = res.frame_end;

endmodule
